>>> rtl/sidta_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
// No dependencies; used by sidta_div10 and signed_int_to_decimal_ascii_top.
package sidta_pkg;

   localparam int MAG_W      = 32;
   localparam int PROD_W     = 2 * MAG_W;
   localparam int DIGIT_W    = 4;
   localparam int CHAR_W     = 7;
   localparam int MAX_DIGITS = 10;
   localparam int IDX_W      = $clog2(MAX_DIGITS);

   // floor(x / 10) == (x * 0xCCCCCCCD) >> 35 for every 32-bit unsigned x.
   localparam logic [MAG_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
   localparam int               RECIP_SHIFT = 35;
   localparam int               QUOT_W      = PROD_W - RECIP_SHIFT;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

   typedef struct packed {
      logic load;   // take a fresh magnitude
      logic prime;  // multiply the held magnitude
      logic step;   // replace the magnitude by its quotient and multiply that
   } div_ctrl_type;

   typedef struct packed {
      logic               quot_zero;
      logic [DIGIT_W-1:0] digit;
   } div_stat_type;

endpackage

>>> rtl/sidta_div10.sv
// Shared divide-by-ten unit: a registered reciprocal multiply followed by a
// shift-and-add remainder correction. Depends on sidta_pkg.
module sidta_div10 import sidta_pkg::*; (
   input  logic               clock,
   input  div_ctrl_type       ctrl,
   input  logic [MAG_W-1:0]   load_mag,
   output div_stat_type       stat
);

   logic [MAG_W-1:0]  operand_ff;
   logic [MAG_W-1:0]  operand_in;
   logic [PROD_W-1:0] product_ff;
   logic [PROD_W-1:0] product_in;
   logic [MAG_W-1:0]  quotient;
   logic [MAG_W-1:0]  quot_times_ten;
   logic [MAG_W-1:0]  mul_src;

   assign quotient       = {{(MAG_W-QUOT_W){1'b0}}, product_ff[PROD_W-1:RECIP_SHIFT]};
   assign quot_times_ten = {quotient[MAG_W-4:0], 3'b000} + {quotient[MAG_W-2:0], 1'b0};

   // The remainder is below ten, so the low bits of the difference are enough.
   assign stat.digit     = operand_ff[DIGIT_W-1:0] - quot_times_ten[DIGIT_W-1:0];
   assign stat.quot_zero = (quotient == '0);

   assign mul_src = ctrl.step ? quotient : operand_ff;

   always_comb begin
      operand_in = operand_ff;
      product_in = product_ff;
      if (ctrl.load) begin
         operand_in = load_mag;
      end else if (ctrl.step) begin
         operand_in = quotient;
      end
      if (ctrl.prime || ctrl.step) begin
         product_in = PROD_W'(mul_src) * PROD_W'(RECIP_TEN);
      end
   end

   always_ff @(posedge clock) begin
      operand_ff <= operand_in;
      product_ff <= product_in;
   end

endmodule

>>> rtl/signed_int_to_decimal_ascii_top.sv
// Top level of the signed integer to decimal ASCII converter: sequencer,
// digit store and result register. Depends on sidta_pkg and sidta_div10.
//
//   channel  ports                                  direction  handshake
//   request  start, busy, req_value[31:0]           in/out     start && !busy
//   result   rsp_valid, rsp_character[6:0], rsp_last  out      rsp_valid strobe
//
// A number is converted in the multiply state and then the divide state,
// emitted most significant digit first from the emit state and passed
// through the result register; busy falls as the last character is shown.
// The pace is set by the single divide-by-ten unit, which yields one digit
// per cycle, and by the one result port. A minus sign goes out while the
// first digit is being divided. Reset is synchronous and returns the block
// to idle; each result is shown for exactly one cycle and is never held off.
module signed_int_to_decimal_ascii_top import sidta_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [31:0]  req_value,
   output logic                rsp_valid,
   output logic [CHAR_W-1:0]   rsp_character,
   output logic                rsp_last
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic                neg_ff, neg_in;
   logic [IDX_W-1:0]    ndig_ff, ndig_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [DIGIT_W-1:0]  digits_ff [MAX_DIGITS];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   rsp_char_ff, rsp_char_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                accept;
   logic [MAG_W-1:0]    abs_value;
   div_ctrl_type        div_ctrl;
   div_stat_type        div_stat;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign abs_value = req_value[MAG_W-1] ? (MAG_W'(0) - req_value) : req_value;

   sidta_div10 u_div (
      .clock    (clock),
      .ctrl     (div_ctrl),
      .load_mag (abs_value),
      .stat     (div_stat)
   );

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      ndig_in      = ndig_ff;
      idx_in       = idx_ff;
      rsp_valid_in = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      div_ctrl     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               div_ctrl.load = 1'b1;
               neg_in        = req_value[MAG_W-1];
               ndig_in       = '0;
               state_in      = ST_MUL;
            end
         end
         ST_MUL: begin
            div_ctrl.prime = 1'b1;
            if (neg_ff) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_MINUS;
               rsp_last_in  = 1'b0;
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            div_ctrl.step = 1'b1;
            ndig_in       = ndig_ff + IDX_W'(1);
            if (div_stat.quot_zero || ndig_ff == IDX_W'(MAX_DIGITS - 1)) begin
               idx_in   = ndig_ff;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = CHAR_ZERO + CHAR_W'(digits_ff[idx_ff]);
            rsp_last_in  = (idx_ff == '0);
            idx_in       = idx_ff - IDX_W'(1);
            if (idx_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      ndig_ff     <= ndig_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      // Digits arrive least significant first and are read back in reverse.
      if (state_ff == ST_DIV) begin
         digits_ff[ndig_ff] <= div_stat.digit;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTH
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_character == CHAR_MINUS && !rsp_last) ||
                     (rsp_character >= CHAR_ZERO && rsp_character <= CHAR_ZERO + 7'd9)))
      else $error("result character is neither a digit nor a leading minus");

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (idx_ff < ndig_ff))
      else $error("emit index points beyond the digits converted");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("block not busy after accepting a transaction");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> !rsp_valid)
      else $error("result strobe directly after the final character");
`endif

endmodule

>>> tb/signed_int_to_decimal_ascii_top_tb.sv
`timescale 1ns / 1ps
// Testbench for signed_int_to_decimal_ascii_top: sends signed 32-bit numbers and checks
// each emitted ASCII character and its last flag against a predicted text stream.
// Depends on sidta_pkg and the converter RTL.
module signed_int_to_decimal_ascii_top_tb;
   import sidta_pkg::*;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
   } text_char_type;

   localparam int SETTLE_CYCLES = 40;
   localparam int DRAIN_LIMIT   = 2000;
   localparam int PRINT_LIMIT   = 20;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_value;
   logic               rsp_valid;
   logic [CHAR_W-1:0]  rsp_character;
   logic               rsp_last;

   text_char_type expected_text[$];
   int            mismatch_count = 0;

   signed_int_to_decimal_ascii_top dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("%0t ns: %s", $time, what);
      end
   endtask

   // Appends the decimal text of one number, most significant digit first.
   function automatic void predict_decimal_text(input logic [31:0] value);
      logic [31:0]   magnitude;
      logic [3:0]    digit_store[MAX_DIGITS];
      int            digit_count;
      text_char_type c;
      magnitude   = value[31] ? (32'd0 - value) : value;
      digit_count = 0;
      do begin
         digit_store[digit_count] = 4'(magnitude % 32'd10);
         magnitude = magnitude / 32'd10;
         digit_count++;
      end while (magnitude != 32'd0 && digit_count < MAX_DIGITS);
      if (value[31]) begin
         c.character = CHAR_MINUS;
         c.last      = 1'b0;
         expected_text.push_back(c);
      end
      for (int i = digit_count - 1; i >= 0; i--) begin
         c.character = CHAR_ZERO + CHAR_W'(digit_store[i]);
         c.last      = (i == 0);
         expected_text.push_back(c);
      end
   endfunction

   // Mostly no pause, some short ones and the odd long one.
   function automatic int random_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 95) return $urandom_range(10, 4);
      return $urandom_range(60, 20);
   endfunction

   // Three calls in four pick a digit count first, so that lengths are equally likely.
   function automatic logic [31:0] random_number();
      longint lo;
      longint hi;
      longint mag;
      int     n;
      bit     negative;
      if ($urandom_range(3) == 0) return $urandom;
      n        = $urandom_range(10, 1);
      negative = 1'($urandom_range(1));
      lo = 1;
      for (int i = 1; i < n; i++) lo = lo * 10;
      hi = lo * 10 - 1;
      if (n == 1) lo = 0;
      if (n == 10) hi = negative ? 64'd2147483648 : 64'd2147483647;
      mag = lo + longint'($urandom_range(32'(hi - lo)));
      return negative ? 32'(-mag) : 32'(mag);
   endfunction

   // Holds start low for gap cycles, then presents the number until it is taken.
   task automatic send_number(input logic [31:0] value, input int gap);
      @(negedge clock);
      if (gap > 0) begin
         start     <= 1'b0;
         req_value <= $urandom;
         repeat (gap) @(negedge clock);
      end
      start     <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (busy);
      predict_decimal_text(value);
   endtask

   always @(posedge clock) begin : check_text
      text_char_type want;
      if (!reset && rsp_valid) begin
         if (expected_text.size() == 0) begin
            report_mismatch($sformatf("character %0d with no transaction outstanding",
                                      rsp_character));
         end else begin
            want = expected_text.pop_front();
            if (rsp_character !== want.character) begin
               report_mismatch($sformatf("character %0d, expected %0d",
                                         rsp_character, want.character));
            end
            if (rsp_last !== want.last) begin
               report_mismatch($sformatf("last flag %b, expected %b on character %0d",
                                         rsp_last, want.last, want.character));
            end
         end
      end
   end

   // Zero, 1 to 3 and 9 to 10 digit values, both signs and the most negative value.
   task automatic test_directed_values();
      logic [31:0] values[$];
      values = '{32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99,
                 32'd100, -32'sd100, 32'd5, 32'd42, 32'd999999999, 32'd1000000000,
                 -32'sd1000000000, 32'd1234567890, -32'sd987654321, 32'd2147483646,
                 32'd2147483647, -32'sd2147483647, 32'h8000_0000, 32'hAAAA_AAAA,
                 32'h5555_5555};
      foreach (values[i]) send_number(values[i], (i % 3 == 0) ? 2 : 0);
   endtask

   task automatic test_random_values();
      repeat (127) send_number(random_number(), random_gap());
   endtask

   // Start stays high throughout, so each number is taken as soon as busy falls.
   task automatic test_back_to_back();
      repeat (60) send_number(random_number(), 0);
   endtask

   task automatic test_long_pauses();
      repeat (60) send_number(random_number(), $urandom_range(1) ? $urandom_range(40, 10) : 0);
   endtask

   task automatic drain_results();
      int waited;
      @(negedge clock);
      start     <= 1'b0;
      req_value <= 32'd0;
      waited = 0;
      while (expected_text.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_text.size() != 0) begin
         report_mismatch($sformatf("%0d characters never arrived", expected_text.size()));
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_value = 32'd0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_values();
      test_random_values();
      test_back_to_back();
      test_long_pauses();
      drain_results();
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
